@@ hdl/exl_pkg.sv @@
`default_nettype none

package exl_pkg;

  localparam int CHAR_W  = 8;
  localparam int KIND_W  = 4;
  localparam int START_W = 12;
  localparam int LEN_W   = 13;
  localparam int MODE_W  = 3;
  localparam int KW_W    = 3;
  localparam int RES_MAX = 3;
  localparam int CNT_W   = 2;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              end_of_line;
  } tok_in_t;

  typedef struct packed {
    logic [KIND_W-1:0]  token_kind;
    logic [START_W-1:0] start_pos;
    logic [LEN_W-1:0]   token_length;
    logic               last_result;
  } tok_out_t;

  typedef struct packed {
    logic [CNT_W-1:0]          cnt;
    tok_out_t [RES_MAX-1:0]    slot;
  } bundle_t;

  localparam logic [MODE_W-1:0] MODE_IDLE   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_IDENT  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_STRING = 3'd2;
  localparam logic [MODE_W-1:0] MODE_INT    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_REAL   = 3'd4;

  localparam logic [KIND_W-1:0] KIND_EOL    = 4'd0;
  localparam logic [KIND_W-1:0] KIND_IDENT  = 4'd1;
  localparam logic [KIND_W-1:0] KIND_PRINT  = 4'd2;
  localparam logic [KIND_W-1:0] KIND_STRING = 4'd3;
  localparam logic [KIND_W-1:0] KIND_INT    = 4'd4;
  localparam logic [KIND_W-1:0] KIND_REAL   = 4'd5;
  localparam logic [KIND_W-1:0] KIND_EQUAL  = 4'd6;
  localparam logic [KIND_W-1:0] KIND_SEMI   = 4'd7;
  localparam logic [KIND_W-1:0] KIND_POWER  = 4'd8;
  localparam logic [KIND_W-1:0] KIND_PLUS   = 4'd9;
  localparam logic [KIND_W-1:0] KIND_MINUS  = 4'd10;
  localparam logic [KIND_W-1:0] KIND_SLASH  = 4'd11;
  localparam logic [KIND_W-1:0] KIND_STAR   = 4'd12;
  localparam logic [KIND_W-1:0] KIND_RPAREN = 4'd13;
  localparam logic [KIND_W-1:0] KIND_LPAREN = 4'd14;
  localparam logic [KIND_W-1:0] KIND_BAD    = 4'd15;

  localparam logic [KW_W-1:0] KW_ZERO  = 3'd0;
  localparam logic [KW_W-1:0] KW_FIRST = 3'd1;
  localparam logic [KW_W-1:0] KW_DONE  = 3'd5;
  localparam logic [KW_W-1:0] KW_FAIL  = 3'd7;

  localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
  localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR     = 8'h0d;
  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0] CH_QUOTE  = 8'h22;
  localparam logic [CHAR_W-1:0] CH_DOT    = 8'h2e;
  localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UP_A   = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UP_Z   = 8'h5a;
  localparam logic [CHAR_W-1:0] CH_LO_A   = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LO_Z   = 8'h7a;
  localparam logic [CHAR_W-1:0] CH_P      = 8'h70;
  localparam logic [CHAR_W-1:0] CH_R      = 8'h72;
  localparam logic [CHAR_W-1:0] CH_I      = 8'h69;
  localparam logic [CHAR_W-1:0] CH_N      = 8'h6e;
  localparam logic [CHAR_W-1:0] CH_T      = 8'h74;
  localparam logic [CHAR_W-1:0] CH_EQUAL  = 8'h3d;
  localparam logic [CHAR_W-1:0] CH_SEMI   = 8'h3b;
  localparam logic [CHAR_W-1:0] CH_CARET  = 8'h5e;
  localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2b;
  localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2d;
  localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2f;
  localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2a;
  localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
  localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;

  // expected byte of "print" at a given match count
  function automatic logic [CHAR_W-1:0] kw_char(input logic [KW_W-1:0] idx);
    logic [CHAR_W-1:0] c;
    case (idx)
      3'd0:    c = CH_P;
      3'd1:    c = CH_R;
      3'd2:    c = CH_I;
      3'd3:    c = CH_N;
      3'd4:    c = CH_T;
      default: c = CH_NUL;
    endcase
    return c;
  endfunction

  function automatic logic [KIND_W-1:0] op_kind(input logic [CHAR_W-1:0] c);
    logic [KIND_W-1:0] k;
    unique case (c)
      CH_EQUAL:  k = KIND_EQUAL;
      CH_SEMI:   k = KIND_SEMI;
      CH_CARET:  k = KIND_POWER;
      CH_PLUS:   k = KIND_PLUS;
      CH_MINUS:  k = KIND_MINUS;
      CH_SLASH:  k = KIND_SLASH;
      CH_STAR:   k = KIND_STAR;
      CH_RPAREN: k = KIND_RPAREN;
      CH_LPAREN: k = KIND_LPAREN;
      default:   k = KIND_BAD;
    endcase
    return k;
  endfunction

  function automatic logic [KIND_W-1:0] flush_kind(input logic [MODE_W-1:0] mode,
                                                   input logic [KW_W-1:0] kw);
    logic [KIND_W-1:0] k;
    case (mode)
      MODE_IDENT: k = (kw == KW_DONE) ? KIND_PRINT : KIND_IDENT;
      MODE_INT:   k = KIND_INT;
      MODE_REAL:  k = KIND_REAL;
      default:    k = KIND_BAD;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

@@ hdl/exl_scan.sv @@
`default_nettype none

module exl_scan #(
  parameter int MAX_LINE_BYTES = 4096
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire exl_pkg::tok_in_t in_data,
  input  wire logic            free,
  output logic                 load,
  output exl_pkg::bundle_t     bundle
);
  import exl_pkg::*;

  localparam int PW = $clog2(MAX_LINE_BYTES);
  localparam int LW = PW + 1;
  localparam logic [PW-1:0] PosLast = PW'(MAX_LINE_BYTES - 1);
  localparam logic [LW-1:0] LenMax  = LW'(MAX_LINE_BYTES);

  tok_in_t           in_r;
  logic              in_vld_r;
  logic [MODE_W-1:0] mode_r, mode_nxt, mode1;
  logic [PW-1:0]     pos_r, pos_nxt;
  logic [PW-1:0]     tstart_r, tstart_nxt, tstart1;
  logic [KW_W-1:0]   kw_r, kw_nxt, kw1;
  logic              tdot_r, tdot_nxt, tdot1;

  logic [CHAR_W-1:0] ch;
  logic              eol, is_alpha, is_digit, is_space, done;
  logic [LW-1:0]     pe;
  logic              a_vld, x_vld, d_vld;
  logic [KIND_W-1:0] a_kind, x_kind;
  logic [LW-1:0]     a_len, x_len;
  logic [PW-1:0]     x_start, d_start;
  tok_out_t          a_item, x_item, d_item;
  bundle_t           bnd;

  function automatic logic [LW-1:0] flush_len(input logic [MODE_W-1:0] mode,
                                              input logic tdot,
                                              input logic [LW-1:0] stop,
                                              input logic [PW-1:0] ts);
    logic [LW-1:0] v;
    v = stop - {1'b0, ts} + ((mode == MODE_REAL) ? LW'(tdot) : '0);
    return (v > LenMax) ? LenMax : v;
  endfunction

  function automatic tok_out_t mk_item(input logic [KIND_W-1:0] kind,
                                       input logic [PW-1:0] start,
                                       input logic [LW-1:0] len);
    tok_out_t t;
    t.token_kind   = kind;
    t.start_pos    = START_W'(start);
    t.token_length = LEN_W'(len);
    t.last_result  = 1'b0;
    return t;
  endfunction

  assign in_stall = in_vld_r && !free;
  assign load     = in_vld_r && free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_vld_r <= 1'b1;
    end else if (load) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_r <= in_data;
    end
  end

  assign ch       = in_r.char_code;
  assign eol      = in_r.end_of_line;
  assign is_alpha = (ch >= CH_LO_A && ch <= CH_LO_Z) || (ch >= CH_UP_A && ch <= CH_UP_Z);
  assign is_digit = (ch >= CH_ZERO && ch <= CH_NINE);
  assign is_space = (ch == CH_SPACE) || (ch >= CH_TAB && ch <= CH_CR);
  assign pe       = {1'b0, pos_r} + LW'(1);

  always_comb begin
    mode1   = mode_r;
    kw1     = kw_r;
    tdot1   = tdot_r;
    tstart1 = tstart_r;
    done    = 1'b0;
    a_vld   = 1'b0;
    a_kind  = flush_kind(mode_r, kw_r);
    a_len   = flush_len(mode_r, tdot_r, {1'b0, pos_r}, tstart_r);

    // continue or close the pending token
    case (mode_r)
      MODE_IDENT: begin
        if (is_alpha || is_digit) begin
          kw1  = (kw_r < KW_DONE && ch == kw_char(kw_r)) ? kw_r + KW_FIRST : KW_FAIL;
          done = 1'b1;
        end else begin
          a_vld = 1'b1;
          mode1 = MODE_IDLE;
        end
      end
      MODE_INT: begin
        if (is_digit) begin
          done = 1'b1;
        end else if (ch == CH_DOT) begin
          mode1 = MODE_REAL;
          tdot1 = 1'b1;
          done  = 1'b1;
        end else begin
          a_vld = 1'b1;
          mode1 = MODE_IDLE;
        end
      end
      MODE_REAL: begin
        if (is_digit) begin
          tdot1 = 1'b0;
          done  = 1'b1;
        end else begin
          a_vld = 1'b1;
          mode1 = MODE_IDLE;
        end
      end
      MODE_STRING: begin
        if (ch == CH_QUOTE) begin
          a_vld  = 1'b1;
          a_kind = KIND_STRING;
          a_len  = pe - {1'b0, tstart_r};
          mode1  = MODE_IDLE;
          done   = 1'b1;
        end else if (ch == CH_NUL) begin
          a_vld = 1'b1;
          mode1 = MODE_IDLE;
        end else begin
          done = 1'b1;
        end
      end
      default: begin
        mode1 = MODE_IDLE;
      end
    endcase

    // byte scanned on its own
    x_vld   = 1'b0;
    x_kind  = op_kind(ch);
    x_start = pos_r;
    x_len   = LW'(1);
    if (!done && !is_space) begin
      if (is_alpha) begin
        mode1   = MODE_IDENT;
        tstart1 = pos_r;
        kw1     = (ch == CH_P) ? KW_FIRST : KW_FAIL;
      end else if (is_digit) begin
        mode1   = MODE_INT;
        tstart1 = pos_r;
        tdot1   = 1'b0;
      end else if (ch == CH_QUOTE) begin
        mode1   = MODE_STRING;
        tstart1 = pos_r;
      end else begin
        x_vld = 1'b1;
      end
    end

    // line end flushes whatever is still open
    d_vld = eol;
    if (eol && mode1 != MODE_IDLE) begin
      x_vld   = 1'b1;
      x_kind  = flush_kind(mode1, kw1);
      x_start = tstart1;
      x_len   = flush_len(mode1, tdot1, pe, tstart1);
    end
    d_start = (pe < LenMax) ? pe[PW-1:0] : PosLast;

    if (eol) begin
      mode_nxt   = MODE_IDLE;
      pos_nxt    = '0;
      tstart_nxt = '0;
      kw_nxt     = KW_ZERO;
      tdot_nxt   = 1'b0;
    end else begin
      mode_nxt   = mode1;
      pos_nxt    = (pe < LenMax) ? pe[PW-1:0] : PosLast;
      tstart_nxt = tstart1;
      kw_nxt     = kw1;
      tdot_nxt   = tdot1;
    end
  end

  always_comb begin
    a_item = mk_item(a_kind, tstart_r, a_len);
    x_item = mk_item(x_kind, x_start, x_len);
    d_item = mk_item(KIND_EOL, d_start, '0);
    bnd.cnt = CNT_W'({1'b0, a_vld} + {1'b0, x_vld} + {1'b0, d_vld});
    bnd.slot[0] = a_vld ? a_item : (x_vld ? x_item : d_item);
    bnd.slot[1] = (a_vld && x_vld) ? x_item : d_item;
    bnd.slot[2] = d_item;
    for (int i = 0; i < RES_MAX; i++) begin
      bnd.slot[i].last_result = (CNT_W'(i + 1) == bnd.cnt);
    end
  end

  assign bundle = bnd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IDLE;
      pos_r    <= '0;
      tstart_r <= '0;
      kw_r     <= KW_ZERO;
      tdot_r   <= 1'b0;
    end else if (load) begin
      mode_r   <= mode_nxt;
      pos_r    <= pos_nxt;
      tstart_r <= tstart_nxt;
      kw_r     <= kw_nxt;
      tdot_r   <= tdot_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hdl/exl_drain.sv @@
`default_nettype none

module exl_drain (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             load,
  input  wire exl_pkg::bundle_t bundle,
  output logic                  free,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output exl_pkg::tok_out_t     out_data
);
  import exl_pkg::*;

  logic [CNT_W-1:0]       cnt_r;
  logic [CNT_W-1:0]       idx_r;
  logic [CNT_W-1:0]       idx_inc;
  tok_out_t [RES_MAX-1:0] slot_r;

  assign idx_inc   = idx_r + CNT_W'(1);
  assign out_valid = (idx_r != cnt_r);
  // free when nothing is queued, or once the last queued result leaves this cycle
  assign free      = !out_valid || (idx_inc == cnt_r && !out_stall);

  always_comb begin
    case (idx_r)
      2'd1:    out_data = slot_r[1];
      2'd2:    out_data = slot_r[2];
      default: out_data = slot_r[0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      idx_r <= '0;
    end else if (load) begin
      cnt_r <= bundle.cnt;
      idx_r <= '0;
    end else if (out_valid && !out_stall) begin
      idx_r <= idx_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot_r <= bundle.slot;
    end
  end

endmodule

`default_nettype wire

@@ hdl/expression_line_lexer.sv @@
// path: input register, then the drain's result register once it is free
// throughput: one byte per cycle while a byte yields at most one token and
// out_stall is low; extra tokens of a byte (up to 3) hold back the input
// reset: synchronous active-low rst_n empties both stages and returns the
// scanner to idle at line position zero
`default_nettype none

module expression_line_lexer #(
  parameter int MAX_LINE_BYTES = 4096
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire exl_pkg::tok_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output exl_pkg::tok_out_t      out_data
);
  import exl_pkg::*;

  logic    free;
  logic    load;
  bundle_t bundle;

  exl_scan #(
    .MAX_LINE_BYTES(MAX_LINE_BYTES)
  ) u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .free     (free),
    .load     (load),
    .bundle   (bundle)
  );

  exl_drain u_drain (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .bundle    (bundle),
    .free      (free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  a_stall_needs_backlog: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no result waiting");

  a_eol_closes_burst: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.token_kind == KIND_EOL) |->
      (out_data.last_result && out_data.token_length == '0))
    else $error("end-of-line token not last or not empty");

  a_burst_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_data.last_result) |=> out_valid)
    else $error("gap inside a multi-token transfer burst");

endmodule

`default_nettype wire

@@ test/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import exl_pkg::*;

  localparam int LINE_MAX     = 4096;
  localparam int RANDOM_BYTES = 140;
  localparam int LONG_TOKEN   = 24;
  localparam int HOLD_CYCLES  = 100;
  localparam int IDLE_LIMIT   = 1000;
  localparam int DRAIN_CYCLES = 12;

  localparam logic [CHAR_W-1:0] PRINT_SPELLING [5] = '{CH_P, CH_R, CH_I, CH_N, CH_T};
  localparam logic [CHAR_W-1:0] OPERATOR_BYTES [9] = '{
    CH_EQUAL, CH_SEMI, CH_CARET, CH_PLUS, CH_MINUS, CH_SLASH, CH_STAR, CH_RPAREN, CH_LPAREN
  };

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  tok_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  tok_out_t out_data;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit hold_off    = 1'b0;

  int error_count    = 0;
  int bytes_sent     = 0;
  int lines_sent     = 0;
  int tokens_checked = 0;
  int idle_cycles    = 0;

  // scanner state as seen by the predictor
  logic [MODE_W-1:0] scan_state;
  int unsigned       line_pos;
  int unsigned       tok_begin;
  logic [KW_W-1:0]   kw_matched;
  bit                dot_pending;

  tok_out_t          step_tokens[$];
  tok_out_t          expected_tokens[$];
  logic [CHAR_W-1:0] line_buf[$];

  always #1 clk = ~clk;

  expression_line_lexer #(.MAX_LINE_BYTES(LINE_MAX)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  function automatic bit is_letter(input logic [CHAR_W-1:0] c);
    return (c >= CH_LO_A && c <= CH_LO_Z) || (c >= CH_UP_A && c <= CH_UP_Z);
  endfunction

  function automatic bit is_numeral(input logic [CHAR_W-1:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic bit is_blank(input logic [CHAR_W-1:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic [KIND_W-1:0] symbol_kind(input logic [CHAR_W-1:0] c);
    case (c)
      CH_EQUAL:  return KIND_EQUAL;
      CH_SEMI:   return KIND_SEMI;
      CH_CARET:  return KIND_POWER;
      CH_PLUS:   return KIND_PLUS;
      CH_MINUS:  return KIND_MINUS;
      CH_SLASH:  return KIND_SLASH;
      CH_STAR:   return KIND_STAR;
      CH_RPAREN: return KIND_RPAREN;
      CH_LPAREN: return KIND_LPAREN;
      default:   return KIND_BAD;
    endcase
  endfunction

  function automatic void clear_scanner();
    scan_state  = MODE_IDLE;
    line_pos    = 0;
    tok_begin   = 0;
    kw_matched  = KW_ZERO;
    dot_pending = 1'b0;
  endfunction

  function automatic void add_token(input logic [KIND_W-1:0] kind, input int unsigned start,
                                    input int unsigned len);
    tok_out_t t;
    if (step_tokens.size() >= RES_MAX) return;
    if (len > LINE_MAX) len = LINE_MAX;
    t.token_kind   = kind;
    t.start_pos    = START_W'(start);
    t.token_length = LEN_W'(len);
    t.last_result  = 1'b0;
    step_tokens.push_back(t);
  endfunction

  // pending token ends just before end_pos
  function automatic void close_token(input int unsigned end_pos);
    int unsigned len;
    len = (end_pos >= tok_begin) ? end_pos - tok_begin : 0;
    case (scan_state)
      MODE_IDENT:  add_token((kw_matched == KW_DONE) ? KIND_PRINT : KIND_IDENT, tok_begin, len);
      MODE_INT:    add_token(KIND_INT, tok_begin, len);
      MODE_REAL:   add_token(KIND_REAL, tok_begin, len + dot_pending);
      MODE_STRING: add_token(KIND_BAD, tok_begin, len);
      default: ;
    endcase
    scan_state = MODE_IDLE;
  endfunction

  function automatic void predict_byte(input tok_in_t item);
    logic [CHAR_W-1:0] c;
    int unsigned       p;
    int unsigned       end_pos;
    bit                consumed;
    c        = item.char_code;
    p        = line_pos;
    consumed = 1'b0;
    step_tokens.delete();
    case (scan_state)
      MODE_IDENT: begin
        if (is_letter(c) || is_numeral(c)) begin
          if (kw_matched < KW_DONE && c == PRINT_SPELLING[kw_matched]) kw_matched = kw_matched + 1'b1;
          else kw_matched = KW_FAIL;
          consumed = 1'b1;
        end else begin
          close_token(p);
        end
      end
      MODE_INT: begin
        if (is_numeral(c)) begin
          consumed = 1'b1;
        end else if (c == CH_DOT) begin
          scan_state  = MODE_REAL;
          dot_pending = 1'b1;
          consumed    = 1'b1;
        end else begin
          close_token(p);
        end
      end
      MODE_REAL: begin
        if (is_numeral(c)) begin
          dot_pending = 1'b0;
          consumed    = 1'b1;
        end else begin
          close_token(p);
        end
      end
      MODE_STRING: begin
        if (c == CH_QUOTE) begin
          add_token(KIND_STRING, tok_begin, p + 1 - tok_begin);
          scan_state = MODE_IDLE;
          consumed   = 1'b1;
        end else if (c == CH_NUL) begin
          close_token(p);
        end else begin
          consumed = 1'b1;
        end
      end
      default: scan_state = MODE_IDLE;
    endcase

    if (!consumed && !is_blank(c)) begin
      if (is_letter(c)) begin
        scan_state = MODE_IDENT;
        tok_begin  = p;
        kw_matched = (c == CH_P) ? KW_FIRST : KW_FAIL;
      end else if (is_numeral(c)) begin
        scan_state  = MODE_INT;
        tok_begin   = p;
        dot_pending = 1'b0;
      end else if (c == CH_QUOTE) begin
        scan_state = MODE_STRING;
        tok_begin  = p;
      end else begin
        add_token(symbol_kind(c), p, 1);
      end
    end

    if (item.end_of_line) begin
      end_pos = p + 1;
      if (scan_state != MODE_IDLE) close_token(end_pos);
      add_token(KIND_EOL, (end_pos < LINE_MAX) ? end_pos : LINE_MAX - 1, 0);
      clear_scanner();
    end else if (p + 1 < LINE_MAX) begin
      line_pos = p + 1;
    end else begin
      line_pos = LINE_MAX - 1;
    end

    if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last_result = 1'b1;
    foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
  endfunction

  function automatic int pick_gap(input int pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_byte(input logic [CHAR_W-1:0] c, input bit eol);
    tok_in_t item;
    int      gap;
    item.char_code   = c;
    item.end_of_line = eol;
    gap = pick_gap(tx_idle_pct);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  <= item;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_byte(item);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_line();
    for (int i = 0; i < line_buf.size(); i++) send_byte(line_buf[i], i == line_buf.size() - 1);
    line_buf.delete();
    lines_sent++;
  endtask

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endfunction

  function automatic logic [CHAR_W-1:0] random_letter();
    int r;
    r = $urandom_range(0, 51);
    return (r < 26) ? CH_LO_A + CHAR_W'(r) : CH_UP_A + CHAR_W'(r - 26);
  endfunction

  function automatic logic [CHAR_W-1:0] random_alnum();
    if ($urandom_range(0, 3) == 0) return CH_ZERO + CHAR_W'($urandom_range(0, 9));
    return random_letter();
  endfunction

  function automatic logic [CHAR_W-1:0] random_digit();
    return CH_ZERO + CHAR_W'($urandom_range(0, 9));
  endfunction

  function automatic logic [CHAR_W-1:0] random_blank();
    if ($urandom_range(0, 1) == 0) return CH_SPACE;
    return CHAR_W'($urandom_range(CH_TAB, CH_CR));
  endfunction

  function automatic logic [CHAR_W-1:0] string_byte();
    logic [CHAR_W-1:0] c;
    if ($urandom_range(0, 19) == 0) return CH_NUL;
    c = CHAR_W'($urandom_range(1, 255));
    return (c == CH_QUOTE) ? CH_LO_A : c;
  endfunction

  function automatic void push_random_token();
    int n;
    case ($urandom_range(0, 11))
      0, 1: begin
        line_buf.push_back(random_letter());
        repeat ($urandom_range(0, 5)) line_buf.push_back(random_alnum());
      end
      2: begin
        // keyword, a prefix of it, or a longer word
        n = $urandom_range(1, 5);
        for (int i = 0; i < n; i++) line_buf.push_back(PRINT_SPELLING[i]);
        if ($urandom_range(0, 2) == 0) line_buf.push_back(random_alnum());
      end
      3: repeat ($urandom_range(1, 4)) line_buf.push_back(random_digit());
      4: begin
        repeat ($urandom_range(1, 3)) line_buf.push_back(random_digit());
        line_buf.push_back(CH_DOT);
        repeat ($urandom_range(0, 3)) line_buf.push_back(random_digit());
      end
      5: begin
        line_buf.push_back(CH_QUOTE);
        repeat ($urandom_range(0, 5)) line_buf.push_back(string_byte());
        line_buf.push_back(CH_QUOTE);
      end
      6, 7, 8: line_buf.push_back(OPERATOR_BYTES[$urandom_range(0, 8)]);
      9: line_buf.push_back(CHAR_W'($urandom_range(0, 255)));
      10: begin
        // number running straight into a word
        repeat ($urandom_range(1, 2)) line_buf.push_back(random_digit());
        line_buf.push_back(random_letter());
      end
      default: begin
        // real followed by a second dot
        line_buf.push_back(random_digit());
        line_buf.push_back(CH_DOT);
        repeat ($urandom_range(0, 2)) line_buf.push_back(random_digit());
        line_buf.push_back(CH_DOT);
      end
    endcase
  endfunction

  function automatic void build_random_line();
    repeat ($urandom_range(1, 8)) begin
      push_random_token();
      if ($urandom_range(0, 1) == 0) line_buf.push_back(random_blank());
    end
    if ($urandom_range(0, 9) == 0) begin
      line_buf.push_back(CH_QUOTE);
      repeat ($urandom_range(0, 4)) line_buf.push_back(string_byte());
    end
  endfunction

  task automatic test_keyword_and_real();
    tx_idle_pct = 30;
    rx_idle_pct = 30;
    push_text("print 3.");
    send_line();
  endtask

  task automatic test_operators_and_string();
    push_text("( a^2.5)*7/\"q\"-+=;");
    send_line();
  endtask

  task automatic test_string_faults();
    line_buf.push_back(CH_QUOTE);
    line_buf.push_back(CH_LO_Z);
    line_buf.push_back(CH_NUL);
    line_buf.push_back(8'hff);
    send_line();
    push_text("\"a");
    send_line();
    push_text(" ");
    send_line();
  endtask

  task automatic test_long_lines();
    tx_idle_pct = 10;
    rx_idle_pct = 10;
    repeat (LONG_TOKEN) line_buf.push_back(CH_LO_A);
    send_line();
    line_buf.push_back(CH_QUOTE);
    repeat (LONG_TOKEN) line_buf.push_back(CH_LO_Z);
    line_buf.push_back(CH_QUOTE);
    line_buf.push_back(CH_PLUS);
    send_line();
  endtask

  task automatic test_back_pressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_off    = 1'b1;
    repeat (10) push_text("+-*/");
    send_line();
  endtask

  task automatic test_random_lines();
    int first_byte;
    first_byte = bytes_sent;
    while (bytes_sent - first_byte < RANDOM_BYTES) begin
      case ($urandom_range(0, 3))
        0: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
        1: begin tx_idle_pct = 30; rx_idle_pct = 30; end
        2: begin tx_idle_pct = 60; rx_idle_pct = 10; end
        default: begin tx_idle_pct = 10; rx_idle_pct = 60; end
      endcase
      build_random_line();
      send_line();
    end
  endtask

  initial begin : result_sink
    int n;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        hold_off = 1'b0;
        n = HOLD_CYCLES;
      end else begin
        n = pick_gap(rx_idle_pct);
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : token_check
    tok_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      tokens_checked++;
      if (expected_tokens.size() == 0) begin
        $error("unexpected token: kind %0d start %0d length %0d", out_data.token_kind,
               out_data.start_pos, out_data.token_length);
        error_count++;
      end else begin
        want = expected_tokens.pop_front();
        if (out_data.token_kind !== want.token_kind) begin
          $error("token_kind: expected %0d, got %0d", want.token_kind, out_data.token_kind);
          error_count++;
        end
        if (out_data.start_pos !== want.start_pos) begin
          $error("start_pos: expected %0d, got %0d", want.start_pos, out_data.start_pos);
          error_count++;
        end
        if (out_data.token_length !== want.token_length) begin
          $error("token_length: expected %0d, got %0d", want.token_length,
                 out_data.token_length);
          error_count++;
        end
        if (out_data.last_result !== want.last_result) begin
          $error("last_result: expected %0d, got %0d", want.last_result, out_data.last_result);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("no transfer for %0d cycles", idle_cycles);
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    clear_scanner();
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    test_keyword_and_real();
    test_operators_and_string();
    test_string_faults();
    test_long_lines();
    test_back_pressure();
    test_random_lines();

    in_valid <= 1'b0;
    while (expected_tokens.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d bytes in %0d lines, %0d tokens checked", bytes_sent, lines_sent,
             tokens_checked);
    $display("keyword, all token kinds, string faults, long tokens and output hold-off");
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
